// ----- rtl/sjis_pkg.sv -----
// shared types and constants of the shift-jis to utf-8 decoder
`timescale 1ns / 1ps
`default_nettype none

package sjis_pkg;

    // conversion table geometry
    localparam int unsigned TableRows  = 60;
    localparam int unsigned TableCols  = 188;
    localparam int unsigned TableDepth = TableRows * TableCols;
    localparam int unsigned CodeWidth  = 16;
    localparam int unsigned IndexWidth = 14;

    // item codes
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // code points
    localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] CP_KANA_BASE   = 16'hFF61;

    // byte classes
    localparam logic [7:0] ASCII_END = 8'h80;
    localparam logic [7:0] KANA_LO   = 8'hA1;
    localparam logic [7:0] KANA_HI   = 8'hDF;
    localparam logic [7:0] LEAD1_LO  = 8'h81;
    localparam logic [7:0] LEAD1_HI  = 8'h9F;
    localparam logic [7:0] LEAD2_LO  = 8'hE0;
    localparam logic [7:0] LEAD2_HI  = 8'hFC;
    localparam logic [7:0] TRAIL1_LO = 8'h40;
    localparam logic [7:0] TRAIL1_HI = 8'h7E;
    localparam logic [7:0] TRAIL2_LO = 8'h80;
    localparam logic [7:0] TRAIL2_HI = 8'hFC;
    localparam logic [7:0] CONT_MASK = 8'h3F;
    localparam logic [7:0] CONT_MARK = 8'h80;

    // most utf-8 bytes one input item can produce
    localparam int unsigned BurstMax = 6;

    typedef struct packed {
        logic        operation;
        logic [7:0]  text_byte;
        logic        end_of_text;
        logic [13:0] entry_index;
        logic [15:0] entry_value;
    } sjis_item_t;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       last_of_run;
    } utf8_item_t;

    // all utf-8 bytes of one item, first byte at index 0
    typedef struct packed {
        logic [BurstMax-1:0][7:0] bytes;
        logic [2:0]               cnt;
    } burst_t;

endpackage

`default_nettype wire

// ----- rtl/shift_jis_to_utf8_decoder.sv -----
// shift-jis to utf-8 decoder top level: byte classing, table lookup, hold of lead bytes
`timescale 1ns / 1ps
`default_nettype none

// an item's first utf-8 byte passes the stage-one, buffer and output registers
// throughput: one input byte per cycle while each item yields at most one byte and the
//   output does not stall; an item yielding more bytes stalls the input while they drain
// a trail that is itself a lead byte stalls the input: the table read decides the hold
// reset: hold state, pipeline and output valid clear at once; table stays undefined

module shift_jis_to_utf8_decoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sjis_valid,
    output logic                      sjis_stall,
    input  wire sjis_pkg::sjis_item_t sjis_item,
    output logic                      utf8_valid,
    input  wire logic                 utf8_stall,
    output sjis_pkg::utf8_item_t      utf8_item
);
    import sjis_pkg::*;

    // encoded form of one code point
    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      len;
    } enc_t;

    // decode item waiting for the table read
    typedef struct packed {
        logic        lookup;     // pair lookup issued to the ram
        logic        fail_pre;   // held lead with a bad trail: replacement first
        logic        fresh_has;  // current byte on its own gives a code point
        logic [15:0] fresh_cp;
        logic        holds;      // current byte becomes the new held lead
    } s1_t;

    function automatic enc_t utf8_enc(input logic [15:0] cp);
        enc_t e;
        e = '0;
        if (cp < 16'h0080)
        begin
            e.b[0] = cp[7:0];
            e.len  = 2'd1;
        end
        else if (cp < 16'h0800)
        begin
            e.b[0] = 8'hC0 | {3'b000, cp[10:6]};
            e.b[1] = CONT_MARK | ({2'b00, cp[5:0]} & CONT_MASK);
            e.len  = 2'd2;
        end
        else
        begin
            e.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
            e.b[1] = CONT_MARK | {2'b00, cp[11:6]};
            e.b[2] = CONT_MARK | {2'b00, cp[5:0]};
            e.len  = 2'd3;
        end
        return e;
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    logic       held_valid_reg;
    logic [5:0] held_row_reg;
    logic       s1_valid_reg;
    s1_t        s1_reg;

    // ------------------------------------------------------------------
    // classify the incoming byte
    // ------------------------------------------------------------------
    logic [7:0]  c;
    logic        is_ascii;
    logic        is_kana;
    logic        is_lead1;
    logic        is_lead2;
    logic        is_trail1;
    logic        is_trail2;
    logic        col_ok;
    logic [5:0]  lead_row;
    logic [7:0]  trail_col;
    logic        fresh_holds;
    logic [15:0] fresh_cp;
    logic        sjis_acc;
    logic        is_decode;
    logic        is_write;
    logic        ram_re;
    logic        ram_we;
    logic [IndexWidth-1:0] look_addr;
    logic [IndexWidth-1:0] ram_addr;
    logic [CodeWidth-1:0]  ram_rdata;

    assign c         = sjis_item.text_byte;
    assign is_ascii  = (c < ASCII_END);
    assign is_kana   = (c >= KANA_LO) && (c <= KANA_HI);
    assign is_lead1  = (c >= LEAD1_LO) && (c <= LEAD1_HI);
    assign is_lead2  = (c >= LEAD2_LO) && (c <= LEAD2_HI);
    assign is_trail1 = (c >= TRAIL1_LO) && (c <= TRAIL1_HI);
    assign is_trail2 = (c >= TRAIL2_LO) && (c <= TRAIL2_HI);
    assign col_ok    = is_trail1 || is_trail2;

    // lead rows: 0x81..0x9f give 0..30, 0xe0..0xfc give 31..59
    assign lead_row  = is_lead1 ? 6'(c - LEAD1_LO) : 6'(c - LEAD2_LO + 8'd31);
    // trail columns: 0x40..0x7e give 0..62, 0x80..0xfc give 63..187
    assign trail_col = is_trail1 ? (c - TRAIL1_LO) : (c - TRAIL2_LO + 8'd63);

    // a lead byte is held unless it ends the text
    assign fresh_holds = (is_lead1 || is_lead2) && !sjis_item.end_of_text;

    always_comb
    begin
        if (is_ascii)
        begin
            fresh_cp = {8'h00, c};
        end
        else if (is_kana)
        begin
            fresh_cp = CP_KANA_BASE + {8'h00, c - KANA_LO};
        end
        else
        begin
            fresh_cp = CP_REPLACEMENT;
        end
    end

    assign sjis_acc  = sjis_valid && !sjis_stall;
    assign is_decode = (sjis_item.operation == OP_DECODE);
    assign is_write  = (sjis_item.operation == OP_WRITE);

    // table address of the pair: row * 188 + column
    assign look_addr = IndexWidth'(held_row_reg) * IndexWidth'(TableCols)
                     + IndexWidth'(trail_col);

    assign ram_re   = sjis_acc && is_decode && held_valid_reg && col_ok;
    assign ram_we   = sjis_acc && is_write
                   && (sjis_item.entry_index < IndexWidth'(TableDepth));
    assign ram_addr = is_write ? sjis_item.entry_index : look_addr;

    sjis_ram #(
        .WIDTH (CodeWidth),
        .DEPTH (TableDepth)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (sjis_item.entry_value),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // second stage: table data back, build the utf-8 bytes of the item
    // ------------------------------------------------------------------
    logic        hit;
    logic        first_has;
    logic [15:0] first_cp;
    logic        second_has;
    logic [15:0] second_cp;
    enc_t        enc0;
    enc_t        enc1;
    burst_t      burst;
    logic        emit_free;
    logic        emit_load;
    logic        s1_adv;

    assign hit = s1_reg.lookup && (ram_rdata != '0);

    always_comb
    begin
        first_has  = 1'b0;
        first_cp   = CP_REPLACEMENT;
        second_has = 1'b0;
        second_cp  = s1_reg.fresh_cp;
        if (hit)
        begin
            // pair complete
            first_has = 1'b1;
            first_cp  = ram_rdata;
        end
        else if (s1_reg.lookup || s1_reg.fail_pre)
        begin
            // failed pair: replacement for the lead, then the byte on its own
            first_has  = 1'b1;
            second_has = s1_reg.fresh_has;
        end
        else
        begin
            first_has = s1_reg.fresh_has;
            first_cp  = s1_reg.fresh_cp;
        end
    end

    assign enc0 = utf8_enc(first_cp);
    assign enc1 = utf8_enc(second_cp);

    always_comb
    begin
        burst            = '0;
        burst.bytes[2:0] = enc0.b;
        case (enc0.len)
            2'd1:    burst.bytes[3:1] = enc1.b;
            2'd2:    burst.bytes[4:2] = enc1.b;
            default: burst.bytes[5:3] = enc1.b;
        endcase
        burst.cnt = (first_has ? {1'b0, enc0.len} : 3'd0)
                  + (second_has ? {1'b0, enc1.len} : 3'd0);
    end

    // an item with no bytes (a held lead) retires without the buffer
    assign s1_adv    = s1_valid_reg && (emit_free || (burst.cnt == 3'd0));
    assign emit_load = s1_adv && (burst.cnt != 3'd0);

    // wait while the second stage is blocked, and while the hold depends on the read
    assign sjis_stall = (s1_valid_reg && !s1_adv)
                     || (s1_valid_reg && s1_reg.lookup && s1_reg.holds);

    sjis_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (emit_load),
        .burst (burst),
        .free  (emit_free),
        .valid (utf8_valid),
        .stall (utf8_stall),
        .item  (utf8_item)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_row_reg   <= 6'd0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (sjis_acc && is_decode)
            begin
                // every decode leaves a hold exactly when the byte itself is a
                // lead that does not end the text; a pair hit undoes it below
                held_valid_reg <= fresh_holds;
                if (fresh_holds)
                begin
                    held_row_reg <= lead_row;
                end
                s1_valid_reg <= 1'b1;
            end
            else
            begin
                if (s1_adv && s1_reg.holds && hit)
                begin
                    held_valid_reg <= 1'b0;
                end
                if (s1_adv)
                begin
                    s1_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sjis_acc && is_decode)
        begin
            s1_reg.lookup    <= held_valid_reg && col_ok;
            s1_reg.fail_pre  <= held_valid_reg && !col_ok;
            s1_reg.fresh_has <= !fresh_holds;
            s1_reg.fresh_cp  <= fresh_cp;
            s1_reg.holds     <= fresh_holds;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_read_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (held_valid_reg && (sjis_item.operation == OP_DECODE)))
        else $error("table read without a held lead byte");

    a_hit_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_reg.holds && hit) |=> !held_valid_reg)
        else $error("completed pair left a lead byte held");

    a_hold_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(held_valid_reg) |-> $past(sjis_acc))
        else $error("hold set without an input transfer");

endmodule

`default_nettype wire

// ----- rtl/sjis_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sjis_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/sjis_emit.sv -----
// byte buffer and output register that hand out one utf-8 byte per transfer
`timescale 1ns / 1ps
`default_nettype none

module sjis_emit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire sjis_pkg::burst_t   burst,
    output logic                    free,
    output logic                    valid,
    input  wire logic               stall,
    output sjis_pkg::utf8_item_t    item
);
    import sjis_pkg::*;

    logic       buf_valid_reg;
    burst_t     buf_reg;
    logic [2:0] idx_reg;
    logic       out_valid_reg;
    utf8_item_t out_reg;

    logic out_load;
    logic pop;
    logic at_end;

    assign out_load = !out_valid_reg || !stall;
    assign pop      = buf_valid_reg && out_load;
    assign at_end   = (idx_reg == (buf_reg.cnt - 3'd1));
    assign free     = !buf_valid_reg || (pop && at_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= pop;
            end
            if (load)
            begin
                buf_valid_reg <= 1'b1;
                idx_reg       <= 3'd0;
            end
            else if (pop)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (at_end)
                begin
                    buf_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= burst;
        end
        if (pop)
        begin
            out_reg.utf8_byte   <= buf_reg.bytes[idx_reg];
            out_reg.last_of_run <= at_end;
        end
    end

    assign valid = out_valid_reg;
    assign item  = out_reg;

endmodule

`default_nettype wire

// ----- tb/shift_jis_to_utf8_decoder_tb.sv -----
// testbench of the shift-jis to utf-8 decoder: directed and random byte streams
`timescale 1ns / 1ps

module shift_jis_to_utf8_decoder_tb;

    import sjis_pkg::*;

    // predicts the utf-8 bytes of every accepted item and checks them in order
    class utf8_scoreboard;
        logic [15:0] code_table [TableDepth];
        bit          written [TableDepth];
        logic [5:0]  held_row;
        bit          held_valid;
        logic [7:0]  run_bytes [$];
        utf8_item_t  expected_q [$];
        int          errors;

        function new();
            held_row   = '0;
            held_valid = 1'b0;
            errors     = 0;
        endfunction

        function int lead_row(logic [7:0] c);
            if (c >= LEAD1_LO && c <= LEAD1_HI)
                return int'(c - LEAD1_LO);
            // second lead range continues after the 31 rows of the first
            if (c >= LEAD2_LO && c <= LEAD2_HI)
                return int'(c - LEAD2_LO) + 31;
            return -1;
        endfunction

        function int trail_col(logic [7:0] c);
            if (c >= TRAIL1_LO && c <= TRAIL1_HI)
                return int'(c - TRAIL1_LO);
            // second trail range continues after the 63 columns of the first
            if (c >= TRAIL2_LO && c <= TRAIL2_HI)
                return int'(c - TRAIL2_LO) + 63;
            return -1;
        endfunction

        function void put_code(logic [15:0] cp);
            if (cp < 16'h0080)
            begin
                run_bytes.push_back(cp[7:0]);
            end
            else if (cp < 16'h0800)
            begin
                run_bytes.push_back(8'hC0 | {3'b000, cp[10:6]});
                run_bytes.push_back(CONT_MARK | {2'b00, cp[5:0]});
            end
            else
            begin
                run_bytes.push_back(8'hE0 | {4'b0000, cp[15:12]});
                run_bytes.push_back(CONT_MARK | {2'b00, cp[11:6]});
                run_bytes.push_back(CONT_MARK | {2'b00, cp[5:0]});
            end
        endfunction

        // a byte seen with no lead byte held
        function void fresh_byte(logic [7:0] c, bit eot);
            int row;
            row = lead_row(c);
            if (c < ASCII_END)
                put_code({8'h00, c});
            else if (c >= KANA_LO && c <= KANA_HI)
                put_code(CP_KANA_BASE + {8'h00, c - KANA_LO});
            else if (row >= 0 && !eot)
            begin
                held_row   = 6'(row);
                held_valid = 1'b1;
            end
            else
                put_code(CP_REPLACEMENT);
        endfunction

        function void note_input(sjis_item_t it);
            int          col;
            logic [15:0] cp;
            utf8_item_t  exp_item;
            run_bytes.delete();
            if (it.operation == OP_WRITE)
            begin
                if (it.entry_index < TableDepth)
                begin
                    code_table[it.entry_index] = it.entry_value;
                    written[it.entry_index]    = 1'b1;
                end
                return;
            end
            if (held_valid)
            begin
                col        = trail_col(it.text_byte);
                held_valid = 1'b0;
                if (col >= 0)
                begin
                    cp = code_table[int'(held_row) * TableCols + col];
                    if (cp != 16'h0000)
                        put_code(cp);
                end
                // failed pair: replacement for the lead, then the byte on its own
                if (run_bytes.size() == 0)
                begin
                    put_code(CP_REPLACEMENT);
                    fresh_byte(it.text_byte, it.end_of_text);
                end
            end
            else
                fresh_byte(it.text_byte, it.end_of_text);
            foreach (run_bytes[i])
            begin
                exp_item.utf8_byte   = run_bytes[i];
                exp_item.last_of_run = (i == run_bytes.size() - 1);
                expected_q.push_back(exp_item);
            end
        endfunction

        function void check_result(utf8_item_t got);
            utf8_item_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected utf-8 byte %h last %b",
                             $realtime, got.utf8_byte, got.last_of_run);
                return;
            end
            want = expected_q.pop_front();
            if (got.utf8_byte !== want.utf8_byte || got.last_of_run !== want.last_of_run)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: utf-8 byte %h last %b, expected %h last %b", $realtime,
                             got.utf8_byte, got.last_of_run, want.utf8_byte, want.last_of_run);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       sjis_valid = 1'b0;
    logic       sjis_stall;
    sjis_item_t sjis_item  = '0;
    logic       utf8_valid;
    logic       utf8_stall = 1'b0;
    utf8_item_t utf8_item;

    // no idling on either side near the end of the run
    bit             quiet = 1'b0;
    utf8_scoreboard sb;

    shift_jis_to_utf8_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sjis_valid (sjis_valid),
        .sjis_stall (sjis_stall),
        .sjis_item  (sjis_item),
        .utf8_valid (utf8_valid),
        .utf8_stall (utf8_stall),
        .utf8_item  (utf8_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard limit on the whole run
    initial
    begin
        #5ms;
        $display("shift_jis_to_utf8_decoder test failed");
        $finish;
    end

    // receiver stalls in bursts of random length
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                utf8_stall <= 1'b1;
                repeat ($urandom_range(0, 7)) @(posedge clk);
            end
            else
                utf8_stall <= 1'b0;
        end
    end

    // every output transfer goes to the checker
    always @(posedge clk)
    begin
        if (rst_n && utf8_valid && !utf8_stall)
            sb.check_result(utf8_item);
    end

    // one input transfer, then maybe a random gap; called at a rising edge
    task automatic send_item(input sjis_item_t it);
        sjis_valid <= 1'b1;
        sjis_item  <= it;
        do
            @(posedge clk);
        while (sjis_stall);
        sb.note_input(it);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            sjis_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic write_entry(input int idx, input logic [15:0] value);
        sjis_item_t it;
        it.operation   = OP_WRITE;
        it.text_byte   = 8'($urandom);
        it.end_of_text = 1'($urandom);
        it.entry_index = 14'(idx);
        it.entry_value = value;
        send_item(it);
    endtask

    // code point of random utf-8 length, sometimes unmapped
    function automatic logic [15:0] random_code();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'h0000;
        if (pick <= 2)
            return 16'($urandom_range(1, 16'h007F));
        if (pick <= 4)
            return 16'($urandom_range(16'h0080, 16'h07FF));
        return 16'($urandom_range(16'h0800, 16'hFFFF));
    endfunction

    // decode one byte; a pair that would read a never written entry gets the entry first
    task automatic decode(input logic [7:0] c, input bit eot);
        sjis_item_t it;
        int         col;
        int         idx;
        col = sb.trail_col(c);
        if (sb.held_valid && col >= 0)
        begin
            idx = int'(sb.held_row) * TableCols + col;
            if (!sb.written[idx])
                write_entry(idx, random_code());
        end
        it.operation   = OP_DECODE;
        it.text_byte   = c;
        it.end_of_text = eot;
        it.entry_index = 14'($urandom);
        it.entry_value = 16'($urandom);
        send_item(it);
    endtask

    // lead, table write while the lead is held, then the trail
    task automatic pair(input logic [7:0] lead, input logic [7:0] trail,
                        input logic [15:0] value, input bit eot);
        decode(lead, 1'b0);
        write_entry(sb.lead_row(lead) * TableCols + sb.trail_col(trail), value);
        decode(trail, eot);
    endtask

    // sender holds off until every expected byte has come out
    task automatic drain();
        sjis_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_lead();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(LEAD1_LO, LEAD1_HI));
        return 8'($urandom_range(LEAD2_LO, LEAD2_HI));
    endfunction

    function automatic logic [7:0] random_trail();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(TRAIL1_LO, TRAIL1_HI));
        return 8'($urandom_range(TRAIL2_LO, TRAIL2_HI));
    endfunction

    initial
    begin
        int         pick;
        int         wait_cycles;
        logic [7:0] lead;
        logic [7:0] trail;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pairs of every utf-8 length, at the corners of the table
        pair(8'h81, 8'h40, 16'h0041, 1'b0);
        pair(8'h9F, 8'hFC, 16'h07FF, 1'b0);
        pair(8'hE0, 8'h7E, 16'h0080, 1'b0);
        pair(8'hFC, 8'hFC, 16'hFFFF, 1'b1);
        pair(8'hE5, 8'h80, 16'h0800, 1'b0);
        // unmapped entry whose trail is itself a lead: replacement, then held again
        pair(8'h88, 8'h9E, 16'h0000, 1'b0);
        // invalid trail that is also an invalid byte: two replacements
        decode(8'hFD, 1'b0);
        // single-byte classes at their extremes
        decode(8'h00, 1'b0);
        decode(8'h7F, 1'b0);
        decode(8'hA1, 1'b0);
        decode(8'hDF, 1'b0);
        decode(8'h80, 1'b0);
        decode(8'hA0, 1'b0);
        decode(8'hFF, 1'b0);
        // lead byte closing the text
        decode(8'h81, 1'b1);
        decode(8'hFC, 1'b1);
        // invalid trail below the trail range, then one in the gap between the trail ranges
        decode(8'h90, 1'b0);
        decode(8'h20, 1'b0);
        decode(8'h82, 1'b0);
        decode(8'h7F, 1'b0);
        // table writes, two out of range, while a lead is held leave the hold alone
        decode(8'h90, 1'b0);
        write_entry(16383, 16'hFFFF);
        write_entry(TableDepth, 16'h1234);
        write_entry(0, 16'h00E9);
        decode(8'hE1, 1'b1);
        // failed pair where the second byte is a lead closing the text
        pair(8'h85, 8'hE2, 16'h0000, 1'b1);
        drain();

        for (int k = 0; k < 150; k++)
        begin
            if (k == 130)
                quiet = 1'b1;
            if (k % 97 == 50)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // mostly well-formed pairs; a few reuse a small corner of the table
                if ($urandom_range(0, 3) == 0)
                begin
                    lead  = LEAD1_LO + 8'($urandom_range(0, 1));
                    trail = TRAIL1_LO + 8'($urandom_range(0, 3));
                end
                else
                begin
                    lead  = random_lead();
                    trail = random_trail();
                end
                decode(lead, 1'b0);
                decode(trail, $urandom_range(0, 7) == 0);
            end
            else if (pick < 50)
                decode(8'($urandom_range(0, 8'h7F)), $urandom_range(0, 7) == 0);
            else if (pick < 62)
                decode(8'($urandom_range(KANA_LO, KANA_HI)), $urandom_range(0, 7) == 0);
            else if (pick < 72)
                decode(random_lead(), $urandom_range(0, 1));
            else if (pick < 86)
                decode(8'($urandom), $urandom_range(0, 3) == 0);
            else if ($urandom_range(0, 3) == 0)
                write_entry($urandom_range(0, 3), random_code());
            else
                write_entry($urandom_range(0, 16383), random_code());
        end

        sjis_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);

        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0d expected utf-8 bytes never arrived", sb.pending());
        end
        if (sb.errors == 0)
            $display("shift_jis_to_utf8_decoder test passed");
        else
            $display("shift_jis_to_utf8_decoder test failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sjis_pkg.sv
rtl/sjis_ram.sv
rtl/sjis_emit.sv
rtl/shift_jis_to_utf8_decoder.sv
tb/shift_jis_to_utf8_decoder_tb.sv
